### design/mvlr_pkg.sv
// ============================================================================
// mvlr_pkg
// Shared types and constants for the MIDI voice limiter and router.
// ============================================================================
`default_nettype none

package mvlr_pkg;

  // Default depth of the held-note list.
  localparam int unsigned MAX_HELD_DEFAULT = 16;

  // Depth of the command queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Width of the voice limit register.
  localparam int unsigned LIMIT_W = 7;

  // Configuration port geometry.
  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned REG_IDX_W  = 2;

  // Register indexes.
  localparam logic [REG_IDX_W-1:0] REG_ROUTE_MODE    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_OUT_CHANNEL   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_VOICE_LIMIT   = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_SYNTH_PRESENT = 2'd3;

  // Route modes. The unused code behaves as external only.
  localparam logic [1:0] ROUTE_INT  = 2'd0;
  localparam logic [1:0] ROUTE_BOTH = 2'd1;
  localparam logic [1:0] ROUTE_EXT  = 2'd2;

  // MIDI status constants.
  localparam logic [7:0] KIND_MASK     = 8'hF0;
  localparam logic [7:0] KIND_NOTE_ON  = 8'h90;
  localparam logic [7:0] KIND_NOTE_OFF = 8'h80;

  // One classified message, as passed from the front to the back.
  typedef struct packed {
    logic               ext_en;
    logic               int_en;
    logic               note_on;
    logic               note_off;
    logic [7:0]         ext_status;
    logic [7:0]         status;
    logic [6:0]         data_one;
    logic [6:0]         data_two;
    logic [LIMIT_W-1:0] limit;
  } cmd_t;

  // One emitted message.
  typedef struct packed {
    logic       to_external;
    logic [7:0] status;
    logic [6:0] data_one;
    logic [6:0] data_two;
    logic       last_of_run;
  } res_t;

  // Queue fill status.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Back-end sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXT,
    ST_SEARCH,
    ST_STEAL,
    ST_ORIG
  } back_state_e;

endpackage

`default_nettype wire

### design/mvlr_front.sv
// ============================================================================
// mvlr_front
// Classifies an incoming message and builds the command for the back end.
// ============================================================================
`default_nettype none

module mvlr_front #(
  parameter int unsigned MAX_HELD = mvlr_pkg::MAX_HELD_DEFAULT
) (
  input  wire logic                        accept_i,
  input  wire logic [7:0]                  status_byte_i,
  input  wire logic [6:0]                  data_one_i,
  input  wire logic [6:0]                  data_two_i,
  input  wire logic [1:0]                  route_mode_i,
  input  wire logic [3:0]                  out_channel_i,
  input  wire logic [mvlr_pkg::LIMIT_W-1:0] voice_limit_i,
  input  wire logic                        synth_present_i,
  output logic                             push_o,
  output mvlr_pkg::cmd_t                   cmd_o
);

  localparam int unsigned LimW = mvlr_pkg::LIMIT_W;

  logic [7:0] kind;
  logic       ext_en;
  logic       int_en;

  assign kind   = status_byte_i & mvlr_pkg::KIND_MASK;
  assign ext_en = (route_mode_i != mvlr_pkg::ROUTE_INT);
  assign int_en = ((route_mode_i == mvlr_pkg::ROUTE_INT) ||
                   (route_mode_i == mvlr_pkg::ROUTE_BOTH)) && synth_present_i;

  // A message that produces no output at all is dropped here.
  assign push_o = accept_i && (ext_en || int_en);

  always_comb begin
    cmd_o            = '0;
    cmd_o.ext_en     = ext_en;
    cmd_o.int_en     = int_en;
    cmd_o.note_on    = (kind == mvlr_pkg::KIND_NOTE_ON) && (data_two_i != 7'd0);
    cmd_o.note_off   = (kind == mvlr_pkg::KIND_NOTE_OFF) ||
                       ((kind == mvlr_pkg::KIND_NOTE_ON) && (data_two_i == 7'd0));
    cmd_o.ext_status = kind | {4'h0, out_channel_i};
    cmd_o.status     = status_byte_i;
    cmd_o.data_one   = data_one_i;
    cmd_o.data_two   = data_two_i;
    cmd_o.limit      = (voice_limit_i > LimW'(MAX_HELD)) ? LimW'(MAX_HELD) : voice_limit_i;
  end

endmodule

`default_nettype wire

### design/mvlr_queue.sv
// ============================================================================
// mvlr_queue
// Short command queue between the front and the back end.
// ============================================================================
`default_nettype none

module mvlr_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire mvlr_pkg::cmd_t push_cmd_i,
  input  wire logic           pop_i,
  output mvlr_pkg::cmd_t      head_o,
  output mvlr_pkg::q_stat_t   stat_o
);

  localparam int unsigned Depth = mvlr_pkg::QUEUE_DEPTH;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  mvlr_pkg::cmd_t  entries_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q,  count_d;
  logic            do_push;
  logic            do_pop;

  assign stat_o.full  = (count_q == CntW'(Depth));
  assign stat_o.empty = (count_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

### design/mvlr_back.sv
// ============================================================================
// mvlr_back
// Executes commands: keeps the held-note list, steals voices, emits results.
// ============================================================================
`default_nettype none

module mvlr_back #(
  parameter int unsigned MAX_HELD = mvlr_pkg::MAX_HELD_DEFAULT
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire mvlr_pkg::cmd_t    head_i,
  input  wire mvlr_pkg::q_stat_t q_stat_i,
  output logic                   pop_o,
  output logic                   res_valid_o,
  output mvlr_pkg::res_t         res_o
);

  localparam int unsigned IdxW = (MAX_HELD > 1) ? $clog2(MAX_HELD) : 1;
  localparam int unsigned CntW = $clog2(MAX_HELD + 1);
  localparam int unsigned LimW = mvlr_pkg::LIMIT_W;

  mvlr_pkg::back_state_e state_q, state_d;
  mvlr_pkg::cmd_t        cmd_q, cmd_d;
  mvlr_pkg::res_t        res_q, res_d;
  logic                  res_valid_q, res_valid_d;
  logic [CntW-1:0]       idx_q, idx_d;
  logic [CntW-1:0]       count_q, count_d;
  logic [6:0]            held_q [MAX_HELD];

  logic                  shift_en;
  logic [CntW-1:0]       shift_from;
  logic                  append;
  logic                  in_range;
  logic                  hit;
  logic                  steal;
  logic [6:0]            held_at_idx;

  assign held_at_idx = held_q[idx_q[IdxW-1:0]];
  assign in_range    = (idx_q < count_q);
  assign hit         = in_range && (held_at_idx == cmd_q.data_one);
  assign steal       = (cmd_q.limit != '0) && (LimW'(count_q) >= cmd_q.limit);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      mvlr_pkg::ST_IDLE: begin
        if (!q_stat_i.empty) begin
          if (head_i.ext_en) begin
            state_d = mvlr_pkg::ST_EXT;
          end else if (head_i.note_on || head_i.note_off) begin
            state_d = mvlr_pkg::ST_SEARCH;
          end else begin
            state_d = mvlr_pkg::ST_ORIG;
          end
        end
      end
      mvlr_pkg::ST_EXT: begin
        if (!cmd_q.int_en) begin
          state_d = mvlr_pkg::ST_IDLE;
        end else if (cmd_q.note_on || cmd_q.note_off) begin
          state_d = mvlr_pkg::ST_SEARCH;
        end else begin
          state_d = mvlr_pkg::ST_ORIG;
        end
      end
      mvlr_pkg::ST_SEARCH: begin
        if (hit || !in_range) begin
          state_d = cmd_q.note_on ? mvlr_pkg::ST_STEAL : mvlr_pkg::ST_ORIG;
        end
      end
      mvlr_pkg::ST_STEAL: begin
        if (!steal) begin
          state_d = mvlr_pkg::ST_ORIG;
        end
      end
      mvlr_pkg::ST_ORIG: begin
        state_d = mvlr_pkg::ST_IDLE;
      end
      default: begin
        state_d = mvlr_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath controls and results.
  always_comb begin
    pop_o       = 1'b0;
    cmd_d       = cmd_q;
    idx_d       = idx_q;
    count_d     = count_q;
    res_d       = res_q;
    res_valid_d = 1'b0;
    shift_en    = 1'b0;
    shift_from  = '0;
    append      = 1'b0;
    case (state_q)
      mvlr_pkg::ST_IDLE: begin
        if (!q_stat_i.empty) begin
          pop_o = 1'b1;
          cmd_d = head_i;
          idx_d = '0;
        end
      end
      mvlr_pkg::ST_EXT: begin
        res_valid_d       = 1'b1;
        res_d.to_external = 1'b1;
        res_d.status      = cmd_q.ext_status;
        res_d.data_one    = cmd_q.data_one;
        res_d.data_two    = cmd_q.data_two;
        res_d.last_of_run = !cmd_q.int_en;
      end
      mvlr_pkg::ST_SEARCH: begin
        if (hit) begin
          shift_en   = 1'b1;
          shift_from = idx_q;
          count_d    = count_q - 1'b1;
        end else if (in_range) begin
          idx_d = idx_q + 1'b1;
        end
      end
      mvlr_pkg::ST_STEAL: begin
        if (steal) begin
          // The oldest note sits at the head of the list.
          res_valid_d       = 1'b1;
          res_d.to_external = 1'b0;
          res_d.status      = mvlr_pkg::KIND_NOTE_OFF;
          res_d.data_one    = held_q[0];
          res_d.data_two    = 7'd0;
          res_d.last_of_run = 1'b0;
          shift_en          = 1'b1;
          count_d           = count_q - 1'b1;
        end else if (count_q < CntW'(MAX_HELD)) begin
          append  = 1'b1;
          count_d = count_q + 1'b1;
        end
      end
      mvlr_pkg::ST_ORIG: begin
        res_valid_d       = 1'b1;
        res_d.to_external = 1'b0;
        res_d.status      = cmd_q.status;
        res_d.data_one    = cmd_q.data_one;
        res_d.data_two    = cmd_q.data_two;
        res_d.last_of_run = 1'b1;
      end
      default: begin
        res_valid_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mvlr_pkg::ST_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    res_q <= res_d;
  end

  // Each list entry below the last takes its upper neighbor when the list
  // closes a gap; any entry takes the new note when it is the first free entry.
  for (genvar j = 0; j < MAX_HELD; j++) begin : g_held
    if (j < MAX_HELD - 1) begin : g_shift
      always_ff @(posedge clk_i) begin
        if (shift_en && (CntW'(j) >= shift_from)) begin
          held_q[j] <= held_q[j + 1];
        end else if (append && (count_q[IdxW-1:0] == IdxW'(j))) begin
          held_q[j] <= cmd_q.data_one;
        end
      end
    end else begin : g_tail
      always_ff @(posedge clk_i) begin
        if (append && (count_q[IdxW-1:0] == IdxW'(j))) begin
          held_q[j] <= cmd_q.data_one;
        end
      end
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

### design/midi_voice_limiter_router_top.sv
// ============================================================================
// midi_voice_limiter_router_top
// MIDI router with an oldest-first held-note list and voice stealing.
// ============================================================================
//
//   Channel   Direction  Handshake                         Payload
//   -------   ---------  --------------------------------  ----------------------
//   message   in         start high while busy low         status/data_one/two
//   result    out        result_valid_o, one cycle each    to_external..last_of_run
//   config    in/out     APB write: psel&penable&pwrite     paddr, pwdata, prdata
//
// A message leaves the queue; the back end then emits the external copy,
// scans the held-note list for the note, steals voices, appends the new
// note and emits the internal copy, each step only where the command needs
// it. The serial scan of the held-note list and the one-voice-per-cycle
// stealing set how long a message takes.
// The front takes a new message while the back still works, until the
// two-entry command queue is full; busy then stays high.
// Reset is asynchronous and active low; it empties the list and the queue
// and restores the register defaults. The held-note entries themselves are
// not cleared: only entries below the fill count are ever read.
// Results cannot be stalled by the receiver: each one is valid for exactly
// one cycle and must be taken then.
// ============================================================================
`default_nettype none

module midi_voice_limiter_router_top #(
  parameter int unsigned MAX_HELD = mvlr_pkg::MAX_HELD_DEFAULT
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // Configuration port.
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [mvlr_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [mvlr_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [mvlr_pkg::APB_DATA_W-1:0] prdata,
  output logic                                 pready,
  // Message input.
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [7:0]                      status_byte_i,
  input  wire logic [6:0]                      data_one_i,
  input  wire logic [6:0]                      data_two_i,
  // Result output.
  output logic                                 result_valid_o,
  output logic                                 to_external_o,
  output logic      [7:0]                      status_out_o,
  output logic      [6:0]                      data_one_out_o,
  output logic      [6:0]                      data_two_out_o,
  output logic                                 last_of_run_o
);

  localparam int unsigned LimW  = mvlr_pkg::LIMIT_W;
  localparam int unsigned DataW = mvlr_pkg::APB_DATA_W;

  // Configuration registers.
  logic [1:0]      route_mode_q,    route_mode_d;
  logic [3:0]      out_channel_q,   out_channel_d;
  logic [LimW-1:0] voice_limit_q,   voice_limit_d;
  logic            synth_present_q, synth_present_d;

  logic                           cfg_write;
  logic [mvlr_pkg::REG_IDX_W-1:0] reg_idx;

  logic              accept;
  logic              push;
  logic              pop;
  mvlr_pkg::cmd_t    push_cmd;
  mvlr_pkg::cmd_t    head_cmd;
  mvlr_pkg::q_stat_t q_stat;
  logic              res_valid;
  mvlr_pkg::res_t    res;

  // --------------------------------------------------------------------------
  // Register access. The port never inserts wait states; registers are decoded
  // on the word index, so every address in the window maps onto one of them.
  // --------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_idx   = paddr[mvlr_pkg::REG_IDX_W+1:2];

  always_comb begin
    route_mode_d    = route_mode_q;
    out_channel_d   = out_channel_q;
    voice_limit_d   = voice_limit_q;
    synth_present_d = synth_present_q;
    if (cfg_write) begin
      case (reg_idx)
        mvlr_pkg::REG_ROUTE_MODE:    route_mode_d    = pwdata[1:0];
        mvlr_pkg::REG_OUT_CHANNEL:   out_channel_d   = pwdata[3:0];
        mvlr_pkg::REG_VOICE_LIMIT:   voice_limit_d   = pwdata[LimW-1:0];
        mvlr_pkg::REG_SYNTH_PRESENT: synth_present_d = pwdata[0];
        default: begin
          route_mode_d = route_mode_q;
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      mvlr_pkg::REG_ROUTE_MODE:    prdata = DataW'(route_mode_q);
      mvlr_pkg::REG_OUT_CHANNEL:   prdata = DataW'(out_channel_q);
      mvlr_pkg::REG_VOICE_LIMIT:   prdata = DataW'(voice_limit_q);
      mvlr_pkg::REG_SYNTH_PRESENT: prdata = DataW'(synth_present_q);
      default:                     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      route_mode_q    <= mvlr_pkg::ROUTE_INT;
      out_channel_q   <= '0;
      voice_limit_q   <= '0;
      synth_present_q <= 1'b1;
    end else begin
      route_mode_q    <= route_mode_d;
      out_channel_q   <= out_channel_d;
      voice_limit_q   <= voice_limit_d;
      synth_present_q <= synth_present_d;
    end
  end

  // --------------------------------------------------------------------------
  // Front: a transaction is accepted whenever the queue has room. Messages
  // that would produce nothing are accepted and then dropped by the front.
  // --------------------------------------------------------------------------
  assign busy   = q_stat.full;
  assign accept = start && !busy;

  mvlr_front #(
    .MAX_HELD (MAX_HELD)
  ) u_front (
    .accept_i        (accept),
    .status_byte_i   (status_byte_i),
    .data_one_i      (data_one_i),
    .data_two_i      (data_two_i),
    .route_mode_i    (route_mode_q),
    .out_channel_i   (out_channel_q),
    .voice_limit_i   (voice_limit_q),
    .synth_present_i (synth_present_q),
    .push_o          (push),
    .cmd_o           (push_cmd)
  );

  mvlr_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head_cmd),
    .stat_o     (q_stat)
  );

  // --------------------------------------------------------------------------
  // Back: walks the held-note list and emits the results of one command.
  // --------------------------------------------------------------------------
  mvlr_back #(
    .MAX_HELD (MAX_HELD)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_cmd),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign result_valid_o = res_valid;
  assign to_external_o  = res.to_external;
  assign status_out_o   = res.status;
  assign data_one_out_o = res.data_one;
  assign data_two_out_o = res.data_two;
  assign last_of_run_o  = res.last_of_run && res_valid;

  // --------------------------------------------------------------------------
  // Checks.
  // --------------------------------------------------------------------------

  // The queue can never report itself full and empty at once.
  a_queue_consistent: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !(q_stat.full && q_stat.empty)
  ) else $error("command queue reports full and empty together");

  // Every internal result that is not the last of its run is a stolen voice.
  a_steal_form: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !to_external_o && !last_of_run_o) |->
      (status_out_o == mvlr_pkg::KIND_NOTE_OFF) && (data_two_out_o == 7'd0)
  ) else $error("non-final internal result is not a stolen note-off");

  // The back end only takes a command that the queue actually holds.
  a_pop_nonempty: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty
  ) else $error("command taken from an empty queue");

endmodule

`default_nettype wire

### sim/voice_route_checker.sv
// ============================================================================
// voice_route_checker
// Predicts and checks every result of the MIDI voice limiter and router.
// ============================================================================
`default_nettype none

module voice_route_checker #(
  parameter int unsigned MAX_HELD = mvlr_pkg::MAX_HELD_DEFAULT
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic                            pready,
  input  wire logic [mvlr_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [mvlr_pkg::APB_DATA_W-1:0] pwdata,
  input  wire logic [mvlr_pkg::APB_DATA_W-1:0] prdata,
  input  wire logic                            start,
  input  wire logic                            busy,
  input  wire logic [7:0]                      msg_status_i,
  input  wire logic [6:0]                      msg_data_one_i,
  input  wire logic [6:0]                      msg_data_two_i,
  input  wire logic                            res_valid_i,
  input  wire logic                            res_external_i,
  input  wire logic [7:0]                      res_status_i,
  input  wire logic [6:0]                      res_data_one_i,
  input  wire logic [6:0]                      res_data_two_i,
  input  wire logic                            res_last_i,
  output int                                   mismatch_cnt_o,
  output int                                   pending_o,
  output int                                   accepted_o,
  output int                                   checked_o,
  output int                                   stolen_o
);
  import mvlr_pkg::*;

  localparam int PRINT_LIMIT = 40;

  // Shadow copies of the registers and of the held-note list.
  logic [1:0]         route_mode;
  logic [3:0]         out_channel;
  logic [LIMIT_W-1:0] voice_limit;
  logic               synth_present;
  logic [6:0]         held_notes [MAX_HELD];
  int                 held_cnt;

  res_t due_results [$];
  int   mismatch_cnt;
  int   msgs_accepted;
  int   results_checked;
  int   voices_stolen;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_cnt < PRINT_LIMIT)
      $display("mismatch at %0t: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatch_cnt++;
  endtask

  function automatic res_t mk_result(input logic ext, input logic [7:0] st,
                                     input logic [6:0] a, input logic [6:0] b);
    res_t r;
    r.to_external = ext;
    r.status      = st;
    r.data_one    = a;
    r.data_two    = b;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  // Removes the first occurrence of a note and closes the gap.
  task automatic drop_note(input logic [6:0] note);
    int pos;
    pos = -1;
    for (int i = 0; i < held_cnt; i++)
      if (pos < 0 && held_notes[i] == note) pos = i;
    if (pos >= 0) begin
      for (int j = pos; j + 1 < held_cnt; j++)
        held_notes[j] = held_notes[j + 1];
      held_cnt--;
    end
  endtask

  // Works out every message that one accepted input causes, in order.
  task automatic predict_routing(input logic [7:0] st, input logic [6:0] d1,
                                 input logic [6:0] d2);
    logic [7:0] kind;
    logic [6:0] oldest;
    logic       note_on;
    logic       note_off;
    int         cap;
    int         first;
    res_t       tail;
    kind  = st & KIND_MASK;
    first = due_results.size();
    if (route_mode != ROUTE_INT)
      due_results.push_back(mk_result(1'b1, kind | {4'h0, out_channel}, d1, d2));
    if ((route_mode == ROUTE_INT || route_mode == ROUTE_BOTH) && synth_present) begin
      note_on  = (kind == KIND_NOTE_ON) && (d2 != 7'd0);
      note_off = (kind == KIND_NOTE_OFF) || ((kind == KIND_NOTE_ON) && (d2 == 7'd0));
      if (note_on) begin
        drop_note(d1);
        cap = (voice_limit > MAX_HELD) ? MAX_HELD : voice_limit;
        if (cap > 0) begin
          while (held_cnt >= cap && held_cnt > 0) begin
            oldest = held_notes[0];
            due_results.push_back(mk_result(1'b0, KIND_NOTE_OFF, oldest, 7'd0));
            voices_stolen++;
            drop_note(oldest);
          end
        end
        if (held_cnt < MAX_HELD) begin
          held_notes[held_cnt] = d1;
          held_cnt++;
        end
      end else if (note_off) begin
        drop_note(d1);
      end
      due_results.push_back(mk_result(1'b0, st, d1, d2));
    end
    if (due_results.size() > first) begin
      tail = due_results.pop_back();
      tail.last_of_run = 1'b1;
      due_results.push_back(tail);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    res_t        want;
    logic [31:0] readback;
    if (!rst_ni) begin
      route_mode    = ROUTE_INT;
      out_channel   = 4'd0;
      voice_limit   = '0;
      synth_present = 1'b1;
      held_cnt      = 0;
      due_results.delete();
      mismatch_cnt    = 0;
      msgs_accepted   = 0;
      results_checked = 0;
      voices_stolen   = 0;
    end else begin
      if (res_valid_i) begin
        if (due_results.size() == 0) begin
          report_mismatch("result with nothing expected, status", 32'(res_status_i),
                          32'h0);
        end else begin
          want = due_results.pop_front();
          if (res_external_i !== want.to_external)
            report_mismatch("to_external", 32'(res_external_i), 32'(want.to_external));
          if (res_status_i !== want.status)
            report_mismatch("status_out", 32'(res_status_i), 32'(want.status));
          if (res_data_one_i !== want.data_one)
            report_mismatch("data_one_out", 32'(res_data_one_i), 32'(want.data_one));
          if (res_data_two_i !== want.data_two)
            report_mismatch("data_two_out", 32'(res_data_two_i), 32'(want.data_two));
          if (res_last_i !== want.last_of_run)
            report_mismatch("last_of_run", 32'(res_last_i), 32'(want.last_of_run));
        end
        results_checked++;
      end
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (paddr[APB_ADDR_W-1 -: REG_IDX_W])
            REG_ROUTE_MODE:    route_mode    = pwdata[1:0];
            REG_OUT_CHANNEL:   out_channel   = pwdata[3:0];
            REG_VOICE_LIMIT:   voice_limit   = pwdata[LIMIT_W-1:0];
            REG_SYNTH_PRESENT: synth_present = pwdata[0];
            default: ;
          endcase
        end else begin
          case (paddr[APB_ADDR_W-1 -: REG_IDX_W])
            REG_ROUTE_MODE:    readback = {30'd0, route_mode};
            REG_OUT_CHANNEL:   readback = {28'd0, out_channel};
            REG_VOICE_LIMIT:   readback = {{(32 - LIMIT_W){1'b0}}, voice_limit};
            default:           readback = {31'd0, synth_present};
          endcase
          if (prdata !== readback)
            report_mismatch("register readback", prdata, readback);
        end
      end
      if (start && !busy) begin
        predict_routing(msg_status_i, msg_data_one_i, msg_data_two_i);
        msgs_accepted++;
      end
    end
    mismatch_cnt_o <= mismatch_cnt;
    pending_o      <= due_results.size();
    accepted_o     <= msgs_accepted;
    checked_o      <= results_checked;
    stolen_o       <= voices_stolen;
  end

endmodule

`default_nettype wire

### sim/tb.sv
// ============================================================================
// tb
// Stimulus and verdict for the MIDI voice limiter and router.
// ============================================================================
// A directed opening fills the held-note list, overflows it, retriggers and
// releases notes and sends odd status bytes. Ten register settings follow,
// each with random note traffic drawn from a small pool so that retriggers,
// releases and voice stealing happen often. A separate checker predicts each
// result and compares it; this module only drives and judges.
// ============================================================================
`default_nettype none

module tb;
  import mvlr_pkg::*;

  localparam int unsigned HELD_DEPTH = MAX_HELD_DEFAULT;
  // Generous cap on the run length, well above what a correct run needs.
  localparam int RUN_LIMIT     = 400000;
  // Idle wait after each drain. Three messages can be inside the block at once
  // (two in the queue, one in the back); a message with internal-only routing
  // and no synth is dropped by the front and leaves no result behind.
  localparam int SETTLE_CYCLES = 150;
  localparam int NUM_PHASES    = 10;
  localparam int PHASE_MSGS    = 45;

  typedef struct packed {
    logic [7:0] status;
    logic [6:0] data_one;
    logic [6:0] data_two;
  } midi_msg_t;

  // Register settings per phase. The set covers every route mode including
  // the unused code, both channel extremes, unlimited voices, a limit of one,
  // a limit equal to the list depth, limits above it, and a detached synth.
  int ph_route [NUM_PHASES] = '{1, 0, 1, 2, 3, 1, 0, 1, 1, 0};
  int ph_chan  [NUM_PHASES] = '{15, 0, 7, 3, 12, 5, 0, 9, 1, 0};
  int ph_limit [NUM_PHASES] = '{1, 4, 16, 64, 3, 0, 2, 64, 17, 8};
  int ph_synth [NUM_PHASES] = '{1, 1, 1, 1, 1, 1, 0, 0, 1, 1};
  // Percent of cycles in which the sender holds back.
  int ph_idle  [NUM_PHASES] = '{0, 56, 6, 56, 0, 56, 6, 0, 56, 6};
  // Share of note-ons and width of the note pool. The unlimited phase leans
  // on note-ons over a wide pool so that the list overflows.
  int ph_on    [NUM_PHASES] = '{50, 50, 45, 50, 50, 70, 50, 50, 55, 45};
  int ph_span  [NUM_PHASES] = '{12, 10, 30, 20, 8, 40, 10, 10, 30, 15};

  logic                  clk_i  = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  start;
  logic                  busy;
  logic [7:0]            status_byte_i;
  logic [6:0]            data_one_i;
  logic [6:0]            data_two_i;
  logic                  result_valid_o;
  logic                  to_external_o;
  logic [7:0]            status_out_o;
  logic [6:0]            data_one_out_o;
  logic [6:0]            data_two_out_o;
  logic                  last_of_run_o;

  int mismatch_cnt;
  int pending;
  int accepted;
  int checked;
  int stolen;
  int cycle_count = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  midi_voice_limiter_router_top #(
    .MAX_HELD(HELD_DEPTH)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .start         (start),
    .busy          (busy),
    .status_byte_i (status_byte_i),
    .data_one_i    (data_one_i),
    .data_two_i    (data_two_i),
    .result_valid_o(result_valid_o),
    .to_external_o (to_external_o),
    .status_out_o  (status_out_o),
    .data_one_out_o(data_one_out_o),
    .data_two_out_o(data_two_out_o),
    .last_of_run_o (last_of_run_o)
  );

  voice_route_checker #(
    .MAX_HELD(HELD_DEPTH)
  ) checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .start         (start),
    .busy          (busy),
    .msg_status_i  (status_byte_i),
    .msg_data_one_i(data_one_i),
    .msg_data_two_i(data_two_i),
    .res_valid_i   (result_valid_o),
    .res_external_i(to_external_o),
    .res_status_i  (status_out_o),
    .res_data_one_i(data_one_out_o),
    .res_data_two_i(data_two_out_o),
    .res_last_i    (last_of_run_o),
    .mismatch_cnt_o(mismatch_cnt),
    .pending_o     (pending),
    .accepted_o    (accepted),
    .checked_o     (checked),
    .stolen_o      (stolen)
  );

  // The run is stopped here if the block hangs or loses results.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("run stopped at the cycle limit with %0d results outstanding", pending);
      $display("FAILURE");
      $finish;
    end
  end

  function automatic midi_msg_t midi(input logic [7:0] st, input logic [6:0] a,
                                     input logic [6:0] b);
    midi_msg_t m;
    m.status   = st;
    m.data_one = a;
    m.data_two = b;
    return m;
  endfunction

  // Mostly well-formed note traffic on a small pool of notes; the rest are
  // messages with any status byte from 0x80 to 0xFF and any data values.
  function automatic midi_msg_t pick_message(input int pool_lo, input int span,
                                             input int on_pct);
    int         roll;
    logic [3:0] chan;
    logic [6:0] note;
    roll = $urandom_range(0, 99);
    chan = 4'($urandom_range(0, 15));
    note = 7'(pool_lo + $urandom_range(0, span));
    if (roll < on_pct)
      return midi(KIND_NOTE_ON | {4'h0, chan}, note, 7'($urandom_range(1, 127)));
    if (roll < 85) begin
      // Note-off in either of its two spellings.
      if ($urandom_range(0, 1))
        return midi(KIND_NOTE_OFF | {4'h0, chan}, note, 7'($urandom_range(0, 127)));
      return midi(KIND_NOTE_ON | {4'h0, chan}, note, 7'd0);
    end
    return midi(8'($urandom_range(128, 255)), 7'($urandom_range(0, 127)),
                7'($urandom_range(0, 127)));
  endfunction

  // One APB transaction: setup cycle, then access cycle until pready.
  task automatic apb_access(input logic wr, input logic [REG_IDX_W-1:0] idx,
                            input logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Writes a register and reads it back; the checker judges the readback.
  task automatic program_register(input logic [REG_IDX_W-1:0] idx, input int value);
    apb_access(1'b1, idx, value);
    apb_access(1'b0, idx, 32'd0);
  endtask

  // Offers one message after a random number of idle cycles and holds it
  // until the block takes the transaction.
  task automatic send_message(input midi_msg_t m, input int idle_pct);
    while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
    @(negedge clk_i);
    start         <= 1'b1;
    status_byte_i <= m.status;
    data_one_i    <= m.data_one;
    data_two_i    <= m.data_two;
    do @(posedge clk_i); while (busy);
  endtask

  // Stops sending until every predicted result has come out.
  task automatic drain_results();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    midi_msg_t m;
    int        pool_lo;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    start         <= 1'b0;
    status_byte_i <= KIND_NOTE_OFF;
    data_one_i    <= 7'd0;
    data_two_i    <= 7'd0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed opening at the reset settings: internal only, no voice limit.
    // Sixteen note-ons fill the list, with the lowest and highest note and
    // the velocity extremes among them.
    for (int k = 0; k < 16; k++) begin
      m = midi(KIND_NOTE_ON | 8'($urandom_range(0, 15)),
               (k == 1) ? 7'd127 : k[6:0],
               (k == 0) ? 7'd127 : (k == 1) ? 7'd1 : 7'($urandom_range(1, 127)));
      send_message(m, 0);
    end
    // With the list full and no limit, this note-on passes but is not kept.
    send_message(midi(8'h9A, 7'd64, 7'd64), 0);
    // Retrigger of a held note moves it to the newest position.
    send_message(midi(8'h9F, 7'd127, 7'd100), 0);
    // Note-on with zero velocity releases a note.
    send_message(midi(8'h90, 7'd0, 7'd0), 0);
    send_message(midi(8'h8F, 7'd5, 7'd127), 0);
    // Release of a note that is not held.
    send_message(midi(8'h80, 7'd99, 7'd0), 0);
    // A status byte without its top bit set is passed along unchanged.
    send_message(midi(8'h70, 7'd127, 7'd0), 0);
    send_message(midi(8'hFF, 7'd127, 7'd127), 0);
    send_message(midi(8'hB3, 7'd123, 7'd0), 0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      // Registers change only with the block idle.
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clk_i);
      program_register(REG_ROUTE_MODE, ph_route[p]);
      program_register(REG_OUT_CHANNEL, ph_chan[p]);
      program_register(REG_VOICE_LIMIT, ph_limit[p]);
      program_register(REG_SYNTH_PRESENT, ph_synth[p]);
      pool_lo = $urandom_range(0, 127 - ph_span[p]);
      for (int k = 0; k < PHASE_MSGS; k++) begin
        // Halfway through, the sender waits for the block to empty.
        if (k == PHASE_MSGS / 2)
          drain_results();
        m = pick_message(pool_lo, ph_span[p], ph_on[p]);
        send_message(m, ph_idle[p]);
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Sent %0d messages over %0d register settings; %0d results checked.",
             accepted, NUM_PHASES + 1, checked);
    $display("Voices stolen: %0d. Mismatches: %0d.", stolen, mismatch_cnt);
    if (mismatch_cnt == 0 && pending == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
design/mvlr_pkg.sv
design/mvlr_front.sv
design/mvlr_queue.sv
design/mvlr_back.sv
design/midi_voice_limiter_router_top.sv
sim/voice_route_checker.sv
sim/tb.sv
